// ===== design/tct_pkg.sv =====
// shared types and constants for the text cell frame delta tracker
package tct_pkg;

  localparam int CELL_W     = 32;
  localparam int HALF_W     = 16;
  localparam int COL_W      = 9;
  localparam int ROW_W      = 8;
  localparam int POS_W      = 10;
  localparam int MODE_W     = 2;
  localparam int KIND_W     = 2;
  localparam int OUT_COL_W  = 8;
  localparam int OUT_ROW_W  = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TOTAL_W    = COL_W + ROW_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE     = 2'd0,
    MODE_SWEEP_CLR = 2'd1,
    MODE_SWEEP     = 2'd2,
    MODE_READ      = 2'd3
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_DRAW  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_COLS  = 3'd0,
    CFG_SCREEN_ROWS  = 3'd1,
    CFG_SURFACE_COLS = 3'd2,
    CFG_SURFACE_ROWS = 3'd3,
    CFG_BLANK_GLYPH  = 3'd4,
    CFG_BLANK_COLOR  = 3'd5
  } cfg_idx_e;

  localparam logic [COL_W-1:0]  RST_SCREEN_COLS  = 9'd80;
  localparam logic [ROW_W-1:0]  RST_SCREEN_ROWS  = 8'd25;
  localparam logic [COL_W-1:0]  RST_SURFACE_COLS = 9'd80;
  localparam logic [ROW_W-1:0]  RST_SURFACE_ROWS = 8'd25;
  localparam logic [HALF_W-1:0] RST_BLANK_GLYPH  = 16'd32;
  localparam logic [HALF_W-1:0] RST_BLANK_COLOR  = 16'd0;
  localparam logic [CELL_W-1:0] RST_CELL         = {RST_BLANK_GLYPH, RST_BLANK_COLOR};

  typedef struct packed {
    logic clr;
    logic latch;
    logic check;
    logic div_step;
    logic calc;
    logic rd;
    logic commit;
  } tct_cmd_t;

  typedef struct packed {
    logic sweep;
    logic restart;
    logic dirty;
    logic div_last;
    logic clr_last;
    logic need_emit;
    logic out_free;
  } tct_sts_t;

endpackage

// ===== design/tct_ram.sv =====
// generic single write port ram with registered read
module tct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/tct_ctrl.sv =====
// sequencing state machine for the tracker
module tct_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tct_pkg::tct_sts_t sts_i,
  output tct_pkg::tct_cmd_t cmd_o
);
  import tct_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_ADDR,
    S_RD,
    S_UPD
  } state_e;

  state_e state_q, state_d;
  logic   commit;

  assign commit = (state_q == S_UPD) && (!sts_i.need_emit || sts_i.out_free);

  always_comb begin
    cmd_o          = '0;
    cmd_o.clr      = (state_q == S_CLEAR);
    cmd_o.latch    = (state_q == S_IDLE) && in_valid_i;
    cmd_o.check    = (state_q == S_CHECK);
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.calc     = (state_q == S_ADDR);
    cmd_o.rd       = (state_q == S_RD);
    cmd_o.commit   = commit;
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.sweep && !sts_i.restart && sts_i.dirty) state_d = S_DIV;
        else state_d = S_ADDR;
      end
      S_DIV: begin
        if (sts_i.div_last) state_d = S_ADDR;
      end
      S_ADDR: state_d = S_RD;
      S_RD:   state_d = S_UPD;
      S_UPD: begin
        if (commit) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/tct_datapath.sv =====
// config registers, cell stores, sweep position, divider and result register
module tct_datapath #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 128
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [tct_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [tct_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic [tct_pkg::MODE_W-1:0]          mode_i,
  input  logic signed [tct_pkg::POS_W-1:0]    pos_x_i,
  input  logic signed [tct_pkg::POS_W-1:0]    pos_y_i,
  input  logic [tct_pkg::HALF_W-1:0]          glyph_i,
  input  logic [tct_pkg::HALF_W-1:0]          color_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic [tct_pkg::KIND_W-1:0]          kind_o,
  output logic [tct_pkg::OUT_COL_W-1:0]       cell_col_o,
  output logic [tct_pkg::OUT_ROW_W-1:0]       cell_row_o,
  output logic [tct_pkg::HALF_W-1:0]          cell_glyph_o,
  output logic [tct_pkg::HALF_W-1:0]          cell_color_o,
  output logic                                frame_done_o,
  input  tct_pkg::tct_cmd_t                   cmd_i,
  output tct_pkg::tct_sts_t                   sts_o
);
  import tct_pkg::*;

  localparam int DEPTH  = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(ADDR_W + 1);
  localparam int WIDE_W = (ADDR_W > TOTAL_W) ? ADDR_W : TOTAL_W;
  localparam int SW     = COL_W + 2;

  // configuration
  logic [COL_W-1:0]  scr_cols_q, srf_cols_q;
  logic [ROW_W-1:0]  scr_rows_q, srf_rows_q;
  logic [HALF_W-1:0] blank_glyph_q, blank_color_q;
  logic              dirty_q;

  // current item
  mode_e             mode_q;
  logic [POS_W-1:0]  px_q, py_q;
  logic [CELL_W-1:0] cell_q;

  // sweep position
  logic [ADDR_W-1:0] idx_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;

  // divider
  logic [COL_W-1:0]  rem_q;
  logic [ADDR_W-1:0] quo_q;
  logic [CNT_W-1:0]  cnt_q;

  // resolved cell
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [COL_W-1:0]  icol_q, icol_d;
  logic [ROW_W-1:0]  irow_q, irow_d;
  logic              hit_q, hit_d, last_q;

  logic [ADDR_W-1:0] clr_q;

  // result register
  logic                 out_valid_q;
  kind_e                kind_q, kind_d;
  logic [OUT_COL_W-1:0] ocol_q, ocol_d;
  logic [OUT_ROW_W-1:0] orow_q, orow_d;
  logic [CELL_W-1:0]    odata_q, odata_d;
  logic                 done_q;

  logic [COL_W-1:0]   scols;
  logic [ROW_W-1:0]   srows;
  logic [TOTAL_W-1:0] total;
  logic [CELL_W-1:0]  blank;
  logic               is_sweep, restart, last_d;

  logic [COL_W:0]    trial;
  logic              ge;
  logic [COL_W-1:0]  rem_n;
  logic [ADDR_W-1:0] quo_n;
  logic              div_last;

  logic signed [SW-1:0] px_s, py_s, scols_s, srows_s, dcols_s, drows_s;
  logic signed [SW-1:0] dc, dr, offc, offr, colc, rowc;
  logic                 in_rng;

  logic [CELL_W-1:0] frame_rd, shown_rd;
  logic              emit, differ, frame_we, shown_we, ram_we_any;
  logic [ADDR_W-1:0] waddr;
  logic [CELL_W-1:0] wdata;
  logic              out_free;

  assign blank = {blank_glyph_q, blank_color_q};

  always_comb begin
    if (scr_cols_q == '0) scols = COL_W'(1);
    else if (int'(scr_cols_q) > MAX_COLS) scols = COL_W'(MAX_COLS);
    else scols = scr_cols_q;
    if (scr_rows_q == '0) srows = ROW_W'(1);
    else if (int'(scr_rows_q) > MAX_ROWS) srows = ROW_W'(MAX_ROWS);
    else srows = scr_rows_q;
  end

  assign total    = TOTAL_W'(scols) * TOTAL_W'(srows);
  assign is_sweep = (mode_q == MODE_SWEEP_CLR) || (mode_q == MODE_SWEEP);
  assign restart  = WIDE_W'(idx_q) >= WIDE_W'(total);

  // restoring division of the sweep index by the column count
  assign trial    = {rem_q, quo_q[ADDR_W-1]};
  assign ge       = trial >= {1'b0, scols};
  assign rem_n    = ge ? COL_W'(trial - {1'b0, scols}) : trial[COL_W-1:0];
  assign quo_n    = ADDR_W'({quo_q, ge});
  assign div_last = (cnt_q == CNT_W'(ADDR_W - 1));

  // clipping and centering
  always_comb begin
    px_s    = SW'(signed'(px_q));
    py_s    = SW'(signed'(py_q));
    scols_s = signed'(SW'(scols));
    srows_s = signed'(SW'(srows));
    dcols_s = signed'(SW'(srf_cols_q));
    drows_s = signed'(SW'(srf_rows_q));
    dc      = scols_s - dcols_s;
    dr      = srows_s - drows_s;
    offc    = (dc > 0) ? (dc >>> 1) : '0;
    offr    = (dr > 0) ? (dr >>> 1) : '0;
    colc    = px_s + offc;
    rowc    = py_s + offr;
    in_rng  = !px_q[POS_W-1] && !py_q[POS_W-1] && (px_s < scols_s) && (py_s < srows_s);
  end

  always_comb begin
    case (mode_q)
      MODE_WRITE: begin
        hit_d  = in_rng && (px_s < dcols_s) && (py_s < drows_s) &&
                 (colc < scols_s) && (rowc < srows_s);
        icol_d = colc[COL_W-1:0];
        irow_d = rowc[ROW_W-1:0];
      end
      MODE_READ: begin
        hit_d  = in_rng;
        icol_d = px_q[COL_W-1:0];
        irow_d = py_q[ROW_W-1:0];
      end
      default: begin
        hit_d  = 1'b1;
        icol_d = col_q;
        irow_d = row_q;
      end
    endcase
    addr_d = ADDR_W'(ADDR_W'(irow_d) * ADDR_W'(MAX_COLS)) + ADDR_W'(icol_d);
    last_d = (col_q == scols - COL_W'(1)) && (row_q == srows - ROW_W'(1));
  end

  // update decision once store data is back
  always_comb begin
    differ   = (mode_q == MODE_SWEEP_CLR) && (frame_rd != shown_rd);
    emit     = 1'b0;
    kind_d   = KIND_READ;
    ocol_d   = icol_q[OUT_COL_W-1:0];
    orow_d   = irow_q[OUT_ROW_W-1:0];
    odata_d  = shown_rd;
    frame_we = 1'b0;
    shown_we = 1'b0;
    wdata    = blank;
    case (mode_q)
      MODE_WRITE: begin
        emit     = hit_q && (shown_rd != cell_q);
        kind_d   = KIND_DRAW;
        odata_d  = cell_q;
        frame_we = hit_q;
        shown_we = emit;
        wdata    = cell_q;
      end
      MODE_READ: begin
        emit    = 1'b1;
        kind_d  = KIND_READ;
        if (hit_q) begin
          odata_d = frame_rd;
        end else begin
          ocol_d  = '0;
          orow_d  = '0;
          odata_d = blank;
        end
      end
      default: begin
        emit     = differ || last_q;
        kind_d   = differ ? KIND_CLEAR : KIND_READ;
        odata_d  = differ ? blank : shown_rd;
        frame_we = 1'b1;
        shown_we = differ;
      end
    endcase
  end

  assign waddr      = cmd_i.clr ? clr_q : addr_q;
  assign ram_we_any = cmd_i.clr;

  tct_ram #(
    .WIDTH(CELL_W),
    .DEPTH(DEPTH)
  ) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we_any || (cmd_i.commit && frame_we)),
    .waddr_i(waddr),
    .wdata_i(cmd_i.clr ? RST_CELL : wdata),
    .re_i   (cmd_i.rd && hit_q),
    .raddr_i(addr_q),
    .rdata_o(frame_rd)
  );

  tct_ram #(
    .WIDTH(CELL_W),
    .DEPTH(DEPTH)
  ) u_shown_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we_any || (cmd_i.commit && shown_we)),
    .waddr_i(waddr),
    .wdata_i(cmd_i.clr ? RST_CELL : wdata),
    .re_i   (cmd_i.rd && hit_q),
    .raddr_i(addr_q),
    .rdata_o(shown_rd)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    sts_o           = '0;
    sts_o.sweep     = is_sweep;
    sts_o.restart   = restart;
    sts_o.dirty     = dirty_q;
    sts_o.div_last  = div_last;
    sts_o.clr_last  = (clr_q == ADDR_W'(DEPTH - 1));
    sts_o.need_emit = emit;
    sts_o.out_free  = out_free;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_cols_q    <= RST_SCREEN_COLS;
      scr_rows_q    <= RST_SCREEN_ROWS;
      srf_cols_q    <= RST_SURFACE_COLS;
      srf_rows_q    <= RST_SURFACE_ROWS;
      blank_glyph_q <= RST_BLANK_GLYPH;
      blank_color_q <= RST_BLANK_COLOR;
      dirty_q       <= 1'b0;
      idx_q         <= '0;
      col_q         <= '0;
      row_q         <= '0;
      cnt_q         <= '0;
      clr_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_SCREEN_COLS: begin
            scr_cols_q <= cfg_data_i[COL_W-1:0];
            dirty_q    <= 1'b1;
          end
          CFG_SCREEN_ROWS:  scr_rows_q    <= cfg_data_i[ROW_W-1:0];
          CFG_SURFACE_COLS: srf_cols_q    <= cfg_data_i[COL_W-1:0];
          CFG_SURFACE_ROWS: srf_rows_q    <= cfg_data_i[ROW_W-1:0];
          CFG_BLANK_GLYPH:  blank_glyph_q <= cfg_data_i;
          CFG_BLANK_COLOR:  blank_color_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.clr) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
      if (cmd_i.check && is_sweep) begin
        if (restart) begin
          idx_q   <= '0;
          col_q   <= '0;
          row_q   <= '0;
          dirty_q <= 1'b0;
        end else if (dirty_q) begin
          cnt_q <= '0;
        end
      end
      if (cmd_i.div_step) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (div_last) begin
          col_q   <= rem_n;
          row_q   <= ROW_W'(quo_n);
          dirty_q <= 1'b0;
        end
      end
      if (cmd_i.commit && is_sweep) begin
        if (last_q) begin
          idx_q <= '0;
          col_q <= '0;
          row_q <= '0;
        end else begin
          idx_q <= idx_q + ADDR_W'(1);
          if (col_q == scols - COL_W'(1)) begin
            col_q <= '0;
            row_q <= row_q + ROW_W'(1);
          end else begin
            col_q <= col_q + COL_W'(1);
          end
        end
      end
      if (cmd_i.commit && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q <= mode_e'(mode_i);
      px_q   <= pos_x_i;
      py_q   <= pos_y_i;
      cell_q <= {glyph_i, color_i};
    end
    if (cmd_i.check && is_sweep && !restart && dirty_q) begin
      rem_q <= '0;
      quo_q <= idx_q;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_n;
      quo_q <= quo_n;
    end
    if (cmd_i.calc) begin
      addr_q <= addr_d;
      icol_q <= icol_d;
      irow_q <= irow_d;
      hit_q  <= hit_d;
      last_q <= last_d;
    end
    if (cmd_i.commit && emit) begin
      kind_q  <= kind_d;
      ocol_q  <= ocol_d;
      orow_q  <= orow_d;
      odata_q <= odata_d;
      done_q  <= is_sweep && last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign cell_col_o   = ocol_q;
  assign cell_row_o   = orow_q;
  assign cell_glyph_o = odata_q[CELL_W-1:HALF_W];
  assign cell_color_o = odata_q[HALF_W-1:0];
  assign frame_done_o = done_q;

endmodule

// ===== design/text_cell_frame_delta_tracker.sv =====
// top level: text cell frame delta tracker
// an item is latched in idle, then passes check, address, store read and update; the result is registered at commit
// a new item is taken only in idle, after the previous one commits; an output stall holds the update state
// the first sweep after a screen_cols write adds a divide step per sweep index bit, unless it restarts
// reset clears both cell stores to blank, one address per cycle, over all MAX_COLS*MAX_ROWS addresses
// input stall stays high during that pass; config writes are taken at any time
module text_cell_frame_delta_tracker #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 128
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [tct_pkg::MODE_W-1:0]        mode_i,
  input  logic signed [tct_pkg::POS_W-1:0]  pos_x_i,
  input  logic signed [tct_pkg::POS_W-1:0]  pos_y_i,
  input  logic [tct_pkg::HALF_W-1:0]        glyph_i,
  input  logic [tct_pkg::HALF_W-1:0]        color_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [tct_pkg::KIND_W-1:0]        kind_o,
  output logic [tct_pkg::OUT_COL_W-1:0]     cell_col_o,
  output logic [tct_pkg::OUT_ROW_W-1:0]     cell_row_o,
  output logic [tct_pkg::HALF_W-1:0]        cell_glyph_o,
  output logic [tct_pkg::HALF_W-1:0]        cell_color_o,
  output logic                              frame_done_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tct_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tct_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import tct_pkg::*;

  tct_cmd_t cmd;
  tct_sts_t sts;

  assign cfg_ready_o = 1'b1;

  tct_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  tct_datapath #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .mode_i      (mode_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .glyph_i     (glyph_i),
    .color_i     (color_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .kind_o      (kind_o),
    .cell_col_o  (cell_col_o),
    .cell_row_o  (cell_row_o),
    .cell_glyph_o(cell_glyph_o),
    .cell_color_o(cell_color_o),
    .frame_done_o(frame_done_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ===== tb/text_cell_delta_checker.sv =====
// checker for the text cell frame delta tracker: tracks both cell stores and compares every update
`timescale 1ns / 1ps

module text_cell_delta_checker #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 128
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [tct_pkg::MODE_W-1:0]        mode_i,
  input  logic signed [tct_pkg::POS_W-1:0]  pos_x_i,
  input  logic signed [tct_pkg::POS_W-1:0]  pos_y_i,
  input  logic [tct_pkg::HALF_W-1:0]        glyph_i,
  input  logic [tct_pkg::HALF_W-1:0]        color_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic [tct_pkg::KIND_W-1:0]        kind_i,
  input  logic [tct_pkg::OUT_COL_W-1:0]     cell_col_i,
  input  logic [tct_pkg::OUT_ROW_W-1:0]     cell_row_i,
  input  logic [tct_pkg::HALF_W-1:0]        cell_glyph_i,
  input  logic [tct_pkg::HALF_W-1:0]        cell_color_i,
  input  logic                              frame_done_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [tct_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tct_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output int                                fail_count_o,
  output int                                pending_o,
  output int                                checked_o,
  output int                                frames_o
);
  import tct_pkg::*;

  localparam int CELLS = MAX_COLS * MAX_ROWS;

  typedef struct packed {
    kind_e                 kind;
    logic [OUT_COL_W-1:0]  col;
    logic [OUT_ROW_W-1:0]  row;
    logic [HALF_W-1:0]     glyph;
    logic [HALF_W-1:0]     color;
    logic                  done;
  } cell_update_t;

  logic [CELL_W-1:0] shown_mem [CELLS];
  logic [CELL_W-1:0] frame_mem [CELLS];
  int                sweep_pos;
  logic [COL_W-1:0]  scr_cols;
  logic [ROW_W-1:0]  scr_rows;
  logic [COL_W-1:0]  srf_cols;
  logic [ROW_W-1:0]  srf_rows;
  logic [HALF_W-1:0] blank_glyph;
  logic [HALF_W-1:0] blank_color;
  cell_update_t      due_updates [$];

  function automatic int clamp_dim(input int v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int half_gap(input int scr, input int srf);
    int d;
    d = (scr - srf) / 2;
    return (d > 0) ? d : 0;
  endfunction

  task automatic push_update(input kind_e k, input int col, input int row,
                             input logic [CELL_W-1:0] v, input logic done);
    cell_update_t u;
    u.kind  = k;
    u.col   = OUT_COL_W'(col);
    u.row   = OUT_ROW_W'(row);
    u.glyph = v[CELL_W-1:HALF_W];
    u.color = v[HALF_W-1:0];
    u.done  = done;
    due_updates = {due_updates, u};
  endtask

  task automatic apply_cell_item(input mode_e op, input logic signed [POS_W-1:0] x_in,
                                 input logic signed [POS_W-1:0] y_in,
                                 input logic [HALF_W-1:0] g, input logic [HALF_W-1:0] c);
    int px, py, sc, sr, dc, dr, col, row, addr, total;
    logic [CELL_W-1:0] wr_val, blank;
    logic last, cleared;
    px      = x_in;
    py      = y_in;
    sc      = clamp_dim(scr_cols, MAX_COLS);
    sr      = clamp_dim(scr_rows, MAX_ROWS);
    dc      = srf_cols;
    dr      = srf_rows;
    wr_val  = {g, c};
    blank   = {blank_glyph, blank_color};
    cleared = 1'b0;
    case (op)
      MODE_WRITE: begin
        if (px >= 0 && py >= 0 && px < dc && py < dr && px < sc && py < sr) begin
          col = px + half_gap(sc, dc);
          row = py + half_gap(sr, dr);
          if (col < sc && row < sr) begin
            addr = row * MAX_COLS + col;
            frame_mem[addr] = wr_val;
            if (shown_mem[addr] != wr_val) begin
              shown_mem[addr] = wr_val;
              push_update(KIND_DRAW, col, row, wr_val, 1'b0);
            end
          end
        end
      end
      MODE_READ: begin
        if (px < 0 || py < 0 || px >= sc || py >= sr) begin
          push_update(KIND_READ, 0, 0, blank, 1'b0);
        end else begin
          push_update(KIND_READ, px, py, frame_mem[py * MAX_COLS + px], 1'b0);
        end
      end
      default: begin
        total = sc * sr;
        if (sweep_pos >= total) sweep_pos = 0;
        col  = sweep_pos % sc;
        row  = sweep_pos / sc;
        addr = row * MAX_COLS + col;
        last = (sweep_pos + 1 == total);
        if (op == MODE_SWEEP_CLR && frame_mem[addr] != shown_mem[addr]) begin
          shown_mem[addr] = blank;
          cleared = 1'b1;
        end
        frame_mem[addr] = blank;
        sweep_pos = last ? 0 : sweep_pos + 1;
        if (cleared) begin
          push_update(KIND_CLEAR, col, row, blank, last);
        end else if (last) begin
          push_update(KIND_READ, col, row, shown_mem[addr], 1'b1);
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  task automatic compare_update();
    cell_update_t want;
    if (due_updates.size() == 0) begin
      $display("%0t: unexpected result, actual kind %0d col %0d row %0d glyph %h color %h done %0d",
               $time, kind_i, cell_col_i, cell_row_i, cell_glyph_i, cell_color_i,
               frame_done_i);
      fail_count_o++;
    end else begin
      want = due_updates.pop_front();
      check_field("kind", want.kind, kind_i);
      check_field("cell_col", want.col, cell_col_i);
      check_field("cell_row", want.row, cell_row_i);
      check_field("cell_glyph", want.glyph, cell_glyph_i);
      check_field("cell_color", want.color, cell_color_i);
      check_field("frame_done", want.done, frame_done_i);
      checked_o++;
      if (want.done) frames_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_cols    = RST_SCREEN_COLS;
      scr_rows    = RST_SCREEN_ROWS;
      srf_cols    = RST_SURFACE_COLS;
      srf_rows    = RST_SURFACE_ROWS;
      blank_glyph = RST_BLANK_GLYPH;
      blank_color = RST_BLANK_COLOR;
      for (int i = 0; i < CELLS; i++) begin
        shown_mem[i] = RST_CELL;
        frame_mem[i] = RST_CELL;
      end
      sweep_pos    = 0;
      fail_count_o = 0;
      checked_o    = 0;
      frames_o     = 0;
      due_updates.delete();
    end else begin
      if (out_valid_i && !out_stall_i) compare_update();
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_SCREEN_COLS:  scr_cols    = cfg_data_i[COL_W-1:0];
          CFG_SCREEN_ROWS:  scr_rows    = cfg_data_i[ROW_W-1:0];
          CFG_SURFACE_COLS: srf_cols    = cfg_data_i[COL_W-1:0];
          CFG_SURFACE_ROWS: srf_rows    = cfg_data_i[ROW_W-1:0];
          CFG_BLANK_GLYPH:  blank_glyph = cfg_data_i;
          CFG_BLANK_COLOR:  blank_color = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        apply_cell_item(mode_e'(mode_i), pos_x_i, pos_y_i, glyph_i, color_i);
      end
    end
    pending_o = due_updates.size();
  end

endmodule

// ===== tb/text_cell_frame_delta_tracker_tb.sv =====
// testbench top for the text cell frame delta tracker: stimulus, flow control and verdict
`timescale 1ns / 1ps

module text_cell_frame_delta_tracker_tb;
  import tct_pkg::*;

  localparam int MAX_COLS    = 256;
  localparam int MAX_ROWS    = 128;
  localparam int CYCLE_LIMIT = 600000;

  logic                     clk_i;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid    = 1'b0;
  logic                     in_stall;
  mode_e                    in_mode     = MODE_WRITE;
  logic signed [POS_W-1:0]  in_x        = '0;
  logic signed [POS_W-1:0]  in_y        = '0;
  logic [HALF_W-1:0]        in_glyph    = '0;
  logic [HALF_W-1:0]        in_color    = '0;
  logic                     out_valid;
  logic                     out_stall   = 1'b0;
  logic [KIND_W-1:0]        out_kind;
  logic [OUT_COL_W-1:0]     out_col;
  logic [OUT_ROW_W-1:0]     out_row;
  logic [HALF_W-1:0]        out_glyph;
  logic [HALF_W-1:0]        out_color;
  logic                     out_done;
  logic                     cfg_valid   = 1'b0;
  logic                     cfg_ready;
  cfg_idx_e                 cfg_index   = CFG_SCREEN_COLS;
  logic [CFG_DATA_W-1:0]    cfg_data    = '0;

  int   fail_count, pending, checked, frames;
  int   items_sent  = 0;
  int   cycle_count = 0;
  int   phase;
  bit   quiet       = 1'b0;
  bit   stall_burst = 1'b0;
  int   eff_cols, eff_rows, srf_cols, srf_rows;
  logic [HALF_W-1:0] cur_blank;

  text_cell_frame_delta_tracker #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .mode_i       (in_mode),
    .pos_x_i      (in_x),
    .pos_y_i      (in_y),
    .glyph_i      (in_glyph),
    .color_i      (in_color),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .kind_o       (out_kind),
    .cell_col_o   (out_col),
    .cell_row_o   (out_row),
    .cell_glyph_o (out_glyph),
    .cell_color_o (out_color),
    .frame_done_o (out_done),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  text_cell_delta_checker #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) delta_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .mode_i       (in_mode),
    .pos_x_i      (in_x),
    .pos_y_i      (in_y),
    .glyph_i      (in_glyph),
    .color_i      (in_color),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .kind_i       (out_kind),
    .cell_col_i   (out_col),
    .cell_row_i   (out_row),
    .cell_glyph_i (out_glyph),
    .cell_color_i (out_color),
    .frame_done_i (out_done),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .frames_o     (frames)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d updates still due", cycle_count, pending);
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_burst) begin
        stall_burst = 1'b0;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk_i);
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 32);
      end
    end
  end

  task automatic send_item(input mode_e op, input int x, input int y,
                           input logic [HALF_W-1:0] g, input logic [HALF_W-1:0] c);
    logic taken;
    while (!quiet && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_mode  <= op;
    in_x     <= POS_W'(x);
    in_y     <= POS_W'(y);
    in_glyph <= g;
    in_color <= c;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall;
      @(posedge clk_i);
    end
    items_sent++;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    logic taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = cfg_ready;
      @(posedge clk_i);
    end
  endtask

  task automatic set_regs(input int sc, input int sr, input int fc, input int fr,
                          input logic [HALF_W-1:0] bg, input logic [HALF_W-1:0] bc);
    write_reg(CFG_SCREEN_COLS, CFG_DATA_W'(sc));
    write_reg(CFG_SCREEN_ROWS, CFG_DATA_W'(sr));
    write_reg(CFG_SURFACE_COLS, CFG_DATA_W'(fc));
    write_reg(CFG_SURFACE_ROWS, CFG_DATA_W'(fr));
    write_reg(CFG_BLANK_GLYPH, bg);
    write_reg(CFG_BLANK_COLOR, bc);
    cfg_valid <= 1'b0;
    eff_cols  = (sc < 1) ? 1 : ((sc > MAX_COLS) ? MAX_COLS : sc);
    eff_rows  = (sr < 1) ? 1 : ((sr > MAX_ROWS) ? MAX_ROWS : sr);
    srf_cols  = fc;
    srf_rows  = fr;
    cur_blank = bg;
  endtask

  // wait until every update has arrived, plus slack for items that give none
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic [HALF_W-1:0] pick_half();
    case ($urandom_range(4))
      0:       return HALF_W'($urandom_range(1));
      1:       return cur_blank;
      2:       return $urandom_range(1) ? '1 : '0;
      default: return HALF_W'($urandom_range(65535));
    endcase
  endfunction

  task automatic send_read();
    send_item(MODE_READ, $urandom_range(0, eff_cols), $urandom_range(0, eff_rows),
              pick_half(), pick_half());
  endtask

  task automatic draw_frame(input int sweeps);
    int    writes, pick;
    mode_e sweep_op;
    writes = 2 * eff_cols * eff_rows + 2;
    if (writes > 40) writes = 40;
    writes = $urandom_range(0, writes);
    repeat (writes) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_item(mode_e'($urandom_range(3)), int'($urandom_range(1023)) - 512,
                  int'($urandom_range(1023)) - 512, HALF_W'($urandom_range(65535)),
                  HALF_W'($urandom_range(65535)));
      end else if (pick < 20) begin
        send_read();
      end else begin
        send_item(MODE_WRITE, int'($urandom_range(0, srf_cols + 1)) - 1,
                  int'($urandom_range(0, srf_rows + 1)) - 1, pick_half(), pick_half());
      end
    end
    sweep_op = ($urandom_range(3) == 0) ? MODE_SWEEP : MODE_SWEEP_CLR;
    repeat (sweeps) begin
      if ($urandom_range(9) == 0) send_read();
      send_item(sweep_op, int'($urandom_range(1023)) - 512, int'($urandom_range(1023)) - 512,
                pick_half(), pick_half());
    end
  endtask

  initial begin
    int sc, sr;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // small screen with a surface centered one column in
    set_regs(4, 2, 2, 1, 16'd32, 16'd0);
    send_item(MODE_WRITE, 0, 0, 16'hFFFF, 16'hFFFF);
    send_item(MODE_WRITE, 0, 0, 16'hFFFF, 16'hFFFF);
    send_item(MODE_WRITE, 1, 0, 16'h0000, 16'h0000);
    send_item(MODE_WRITE, 2, 0, 16'h1234, 16'h5678);
    send_item(MODE_WRITE, -1, 0, 16'h1234, 16'h5678);
    send_item(MODE_WRITE, 0, 1, 16'h1234, 16'h5678);
    send_item(MODE_WRITE, 511, 511, 16'h1234, 16'h5678);
    send_item(MODE_READ, 1, 0, 16'h0000, 16'h0000);
    send_item(MODE_READ, -512, -512, 16'h0000, 16'h0000);
    send_item(MODE_READ, 4, 0, 16'h0000, 16'h0000);
    send_item(MODE_READ, 0, 2, 16'h0000, 16'h0000);
    repeat (8) send_item(MODE_SWEEP, 0, 0, 16'h0000, 16'h0000);
    repeat (8) send_item(MODE_SWEEP_CLR, 0, 0, 16'hFFFF, 16'hFFFF);

    phase = 0;
    while (items_sent < 1100 || phase < 8) begin
      settle();
      quiet = (phase == 6 || phase == 7);
      case (phase)
        0: begin
          set_regs(511, 255, 256, 128, 16'hFFFF, 16'hFFFF);
          send_item(MODE_WRITE, 255, 127, 16'hA5A5, 16'h5A5A);
          send_item(MODE_READ, 255, 127, 16'h0000, 16'h0000);
          draw_frame(40);
        end
        1: begin
          set_regs(0, 0, 0, 0, 16'h0000, 16'h0000);
          repeat (4) draw_frame(1);
        end
        2: begin
          set_regs(1, 255, 511, 255, pick_half(), pick_half());
          draw_frame(eff_cols * eff_rows);
        end
        3: begin
          set_regs(256, 1, 200, 1, pick_half(), pick_half());
          draw_frame(eff_cols * eff_rows);
        end
        default: begin
          sc = $urandom_range(1, 9);
          sr = $urandom_range(1, 6);
          set_regs(sc, sr, $urandom_range(0, sc + 2), $urandom_range(0, sr + 2),
                   HALF_W'($urandom_range(65535)), HALF_W'($urandom_range(65535)));
          if (phase == 5) begin
            stall_burst = 1'b1;
            repeat (50) send_read();
          end
          repeat (3) draw_frame(eff_cols * eff_rows);
        end
      endcase
      phase++;
    end
    settle();

    $display("run covered %0d input items over %0d register settings plus a directed start",
             items_sent, phase);
    $display("%0d results compared, %0d frame ends seen, %0d mismatches",
             checked, frames, fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/tct_pkg.sv
design/tct_ram.sv
design/tct_ctrl.sv
design/tct_datapath.sv
design/text_cell_frame_delta_tracker.sv
tb/text_cell_delta_checker.sv
tb/text_cell_frame_delta_tracker_tb.sv
